// ===== hdl/rpff_pkg.sv =====
// rpff_pkg: shared types, constants and register codes of the pit fill filter
// no dependencies; imported by rpff_ctrl, rpff_dp, the top level and the bench

package rpff_pkg;

  // payload widths
  localparam int HEIGHT_BITS = 16;
  localparam int FILL_SUM_W  = 38;
  localparam int MAP_ROWS_W  = 13;
  localparam int MAP_COLS_W  = 11;

  // default storage limits
  localparam int RPFF_MAX_COLS = 1024;
  localparam int RPFF_MAX_ROWS = 4096;

  // configuration port
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = MAP_ROWS_W;
  localparam logic [CFG_INDEX_W-1:0] REG_MAP_ROWS = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAP_COLS = 1'd1;

  // neighbor sum and divide-by-three reciprocal
  localparam int SUM_W       = HEIGHT_BITS + 2;
  localparam int DIV3_SHIFT  = SUM_W + 1;
  localparam int MUL_W       = DIV3_SHIFT;
  localparam int DIV3_MUL    = (2 ** DIV3_SHIFT) / 3 + 1;

  typedef struct packed {
    logic signed [HEIGHT_BITS-1:0] height_in;
    logic                          pad;
  } in_item_t;

  typedef struct packed {
    logic signed [HEIGHT_BITS-1:0] height_out;
    logic                          was_pit;
    logic [HEIGHT_BITS-1:0]        fill_amount;
    logic                          last;
    logic [FILL_SUM_W-1:0]         total_fill;
  } out_item_t;

  // which row store entry a read fetches
  typedef enum logic [1:0] {
    RD_MID   = 2'd0,
    RD_LEFT  = 2'd1,
    RD_RIGHT = 2'd2,
    RD_UP    = 2'd3
  } rd_sel_t;

  typedef struct packed {
    logic    latch;
    logic    store;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    eval;
    logic    div;
    logic    fin;
  } ctrl_cmd_t;

  typedef struct packed {
    logic flushing;
    logic row_end;
    logic emit;
    logic out_full;
  } dp_status_t;

endpackage

// ===== hdl/rpff_ram.sv =====
// rpff_ram: generic single write, single read memory with registered read data
// no dependencies

module rpff_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/rpff_ctrl.sv =====
// rpff_ctrl: sequencer of the pit fill filter, one item at a time
// depends on rpff_pkg; drives the datapath through ctrl_cmd_t

module rpff_ctrl import rpff_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_pad,
  output logic       in_stall,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_RMID   = 9'b000000010,
    S_RLEFT  = 9'b000000100,
    S_RRIGHT = 9'b000001000,
    S_RUP    = 9'b000010000,
    S_CAP    = 9'b000100000,
    S_EVAL   = 9'b001000000,
    S_DIV    = 9'b010000000,
    S_FIN    = 9'b100000000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_stall = (state_r != S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    cmd.rd_sel = RD_MID;
    case (state_r)
      S_IDLE: begin
        // an item that does not fit the current phase is dropped
        if (in_valid && (status.flushing == in_pad)) begin
          if (status.emit) begin
            cmd.latch = 1'b1;
            state_nxt = S_RMID;
          end else begin
            cmd.store = 1'b1;
          end
        end
      end
      S_RMID: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_MID;
        state_nxt  = S_RLEFT;
      end
      S_RLEFT: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_LEFT;
        state_nxt  = S_RRIGHT;
      end
      S_RRIGHT: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_RIGHT;
        state_nxt  = S_RUP;
      end
      S_RUP: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_UP;
        state_nxt  = S_CAP;
      end
      S_CAP: begin
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div   = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        // wait for the output register to free up
        if (!status.out_full) begin
          cmd.fin   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hdl/rpff_dp.sv =====
// rpff_dp: row stores, counters, neighbor sum, mean and output register
// depends on rpff_pkg and rpff_ram; commanded by rpff_ctrl

module rpff_dp import rpff_pkg::*; #(
  parameter int MAX_COLS = RPFF_MAX_COLS,
  parameter int MAX_ROWS = RPFF_MAX_ROWS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  in_item_t               in_data,
  input  ctrl_cmd_t              cmd,
  output dp_status_t             status,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output out_item_t              out_data
);

  localparam int COL_W     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int ECOL_W    = COL_W + 1;
  localparam int ROW_W     = $clog2(MAX_ROWS + 1);
  localparam int AW        = COL_W + 1;
  localparam int RAM_DEPTH = 2 ** AW;
  localparam int HB        = HEIGHT_BITS;
  localparam logic [MUL_W-1:0] DIV3_MUL_C = MUL_W'(DIV3_MUL);

  function automatic logic signed [SUM_W-1:0] sext(input logic signed [HB-1:0] v);
    sext = {{(SUM_W-HB){v[HB-1]}}, v};
  endfunction

  // configuration registers
  logic [MAP_ROWS_W-1:0] map_rows_r, map_rows_nxt;
  logic [MAP_COLS_W-1:0] map_cols_r, map_cols_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    map_rows_nxt = map_rows_r;
    map_cols_nxt = map_cols_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MAP_ROWS: map_rows_nxt = cfg_data[MAP_ROWS_W-1:0];
        REG_MAP_COLS: map_cols_nxt = cfg_data[MAP_COLS_W-1:0];
        default: ;
      endcase
    end
  end

  // effective map size: zero acts as one, clamp to the store size
  logic [ECOL_W-1:0] eff_cols;
  logic [ROW_W-1:0]  eff_rows;

  always_comb begin
    if (map_cols_r == '0) begin
      eff_cols = ECOL_W'(1);
    end else if (32'(map_cols_r) > 32'(MAX_COLS)) begin
      eff_cols = ECOL_W'(MAX_COLS);
    end else begin
      eff_cols = ECOL_W'(map_cols_r);
    end
    if (map_rows_r == '0) begin
      eff_rows = ROW_W'(1);
    end else if (32'(map_rows_r) > 32'(MAX_ROWS)) begin
      eff_rows = ROW_W'(MAX_ROWS);
    end else begin
      eff_rows = ROW_W'(map_rows_r);
    end
  end

  // position counters and derived flags
  logic [ROW_W-1:0]      row_r, row_nxt;
  logic [COL_W-1:0]      col_r, col_nxt;
  logic [FILL_SUM_W-1:0] fill_sum_r, fill_sum_nxt;
  logic [ECOL_W-1:0]     col_inc;
  logic                  flushing, row_end, has_up, has_left, has_right;

  assign col_inc   = {1'b0, col_r} + ECOL_W'(1);
  assign row_end   = (col_inc >= eff_cols);
  assign has_right = !row_end;
  assign has_left  = (col_r != '0);
  assign has_up    = (32'(row_r) >= 32'd2);
  assign flushing  = (row_r >= eff_rows);

  assign status.flushing = flushing;
  assign status.row_end  = row_end;
  assign status.emit     = (row_r != '0);

  // row store: bank is the row parity
  logic          wr_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [HB-1:0] wr_data, rd_data;
  logic signed [HB-1:0] down_r, down_nxt;

  assign wr_en   = cmd.store || (cmd.fin && !flushing);
  assign wr_addr = {row_r[0], col_r};
  assign wr_data = cmd.store ? in_data.height_in : down_r;

  always_comb begin
    case (cmd.rd_sel)
      RD_MID:   rd_addr = {~row_r[0], col_r};
      RD_LEFT:  rd_addr = {~row_r[0], col_r - COL_W'(1)};
      RD_RIGHT: rd_addr = {~row_r[0], col_r + COL_W'(1)};
      RD_UP:    rd_addr = {row_r[0], col_r};
      default:  rd_addr = {~row_r[0], col_r};
    endcase
  end

  rpff_ram #(
    .WIDTH(HB),
    .DEPTH(RAM_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // capture neighbor heights in the cycle after each read
  logic    rd_vld_r, rd_vld_nxt;
  rd_sel_t rd_sel_r, rd_sel_nxt;
  logic signed [HB-1:0] mid_r, left_r, right_r, up_r;
  logic signed [HB-1:0] mid_nxt, left_nxt, right_nxt, up_nxt;

  assign rd_vld_nxt = cmd.rd_en;
  assign rd_sel_nxt = cmd.rd_sel;
  assign down_nxt   = cmd.latch ? in_data.height_in : down_r;

  always_comb begin
    mid_nxt   = mid_r;
    left_nxt  = left_r;
    right_nxt = right_r;
    up_nxt    = up_r;
    if (rd_vld_r) begin
      case (rd_sel_r)
        RD_MID:   mid_nxt   = rd_data;
        RD_LEFT:  left_nxt  = rd_data;
        RD_RIGHT: right_nxt = rd_data;
        RD_UP:    up_nxt    = rd_data;
        default: ;
      endcase
    end
  end

  // neighbor count, sum and pit test
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic [2:0]              n_r, n_nxt, n_now;
  logic                    pit_r, pit_nxt, pit_now;
  logic signed [SUM_W-1:0] sum_now;

  always_comb begin
    n_now   = 3'(has_up) + 3'(!flushing) + 3'(has_left) + 3'(has_right);
    sum_now = (has_up    ? sext(up_r)    : '0)
            + (!flushing ? sext(down_r)  : '0)
            + (has_left  ? sext(left_r)  : '0)
            + (has_right ? sext(right_r) : '0);
    pit_now = (n_now != 3'd0)
           && !(has_up    && (up_r    < mid_r))
           && !(!flushing && (down_r  < mid_r))
           && !(has_left  && (left_r  < mid_r))
           && !(has_right && (right_r < mid_r));
  end

  assign sum_nxt = cmd.eval ? sum_now : sum_r;
  assign n_nxt   = cmd.eval ? n_now   : n_r;
  assign pit_nxt = cmd.eval ? pit_now : pit_r;

  // magnitude divided by the count, truncated toward zero
  logic [SUM_W-1:0]       abs_v, quo_now, quo_r, quo_nxt;
  logic [SUM_W+MUL_W-1:0] prod;
  logic                   neg_r, neg_nxt;

  assign abs_v = sum_r[SUM_W-1] ? (~sum_r + SUM_W'(1)) : sum_r;
  assign prod  = {{MUL_W{1'b0}}, abs_v} * {{SUM_W{1'b0}}, DIV3_MUL_C};

  always_comb begin
    case (n_r)
      3'd2:    quo_now = abs_v >> 1;
      3'd3:    quo_now = prod[DIV3_SHIFT +: SUM_W];
      3'd4:    quo_now = abs_v >> 2;
      default: quo_now = abs_v;
    endcase
  end

  assign quo_nxt = cmd.div ? quo_now        : quo_r;
  assign neg_nxt = cmd.div ? sum_r[SUM_W-1] : neg_r;

  // result assembly and running fill total
  logic signed [SUM_W-1:0] mean, diff;
  logic [HB-1:0]           fill16;
  logic [FILL_SUM_W-1:0]   sum_new;
  logic                    last_now;
  out_item_t               res;

  assign mean     = neg_r ? (~quo_r + SUM_W'(1)) : quo_r;
  assign diff     = mean - sext(mid_r);
  assign fill16   = pit_r ? diff[HB-1:0] : '0;
  assign sum_new  = fill_sum_r + {{(FILL_SUM_W-HB){1'b0}}, fill16};
  assign last_now = flushing && row_end;

  always_comb begin
    res.height_out  = pit_r ? mean[HB-1:0] : mid_r;
    res.was_pit     = pit_r;
    res.fill_amount = fill16;
    res.last        = last_now;
    res.total_fill  = sum_new;
  end

  // counter advance after a stored or emitted item
  always_comb begin
    row_nxt      = row_r;
    col_nxt      = col_r;
    fill_sum_nxt = fill_sum_r;
    if (cmd.fin) begin
      fill_sum_nxt = last_now ? '0 : sum_new;
    end
    if (cmd.store || cmd.fin) begin
      if (row_end) begin
        col_nxt = '0;
        if (flushing) begin
          row_nxt = '0;
        end else begin
          row_nxt = row_r + ROW_W'(1);
        end
      end else begin
        col_nxt = col_inc[COL_W-1:0];
      end
    end
  end

  // output register
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  assign out_valid_nxt   = cmd.fin || (out_valid_r && out_stall);
  assign out_data_nxt    = cmd.fin ? res : out_data_r;
  assign status.out_full = out_valid_r && out_stall;
  assign out_valid       = out_valid_r;
  assign out_data        = out_data_r;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_rows_r  <= MAP_ROWS_W'(1);
      map_cols_r  <= MAP_COLS_W'(1);
      row_r       <= '0;
      col_r       <= '0;
      fill_sum_r  <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      map_rows_r  <= map_rows_nxt;
      map_cols_r  <= map_cols_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      fill_sum_r  <= fill_sum_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rd_sel_r   <= rd_sel_nxt;
    down_r     <= down_nxt;
    mid_r      <= mid_nxt;
    left_r     <= left_nxt;
    right_r    <= right_nxt;
    up_r       <= up_nxt;
    sum_r      <= sum_nxt;
    n_r        <= n_nxt;
    pit_r      <= pit_nxt;
    quo_r      <= quo_nxt;
    neg_r      <= neg_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// ===== hdl/raster_pit_fill_filter_unit.sv =====
// raster_pit_fill_filter_unit: top level of the raster pit fill filter
// depends on rpff_pkg, rpff_ctrl, rpff_dp and rpff_ram
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+------------------------------
//   in_      | in        | in_valid/in_stall  | in_item_t  (height, pad)
//   out_     | out       | out_valid/out_stall| out_item_t (filtered pixel)
//   cfg_     | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// an item of the first map row, or one dropped for its phase, is taken with no stall
// an item that emits a pixel is latched, then goes through four reads of the single read
// port of the row store, one capture, sum and pit test, mean, then the result
// register load, which waits while a held result is stalled
// synchronous active-low reset clears counters, fill total and map size to 1
// in_stall is high while an item is in flight; cfg_ready is always high

module raster_pit_fill_filter_unit import rpff_pkg::*; #(
  parameter int MAX_COLS = RPFF_MAX_COLS,
  parameter int MAX_ROWS = RPFF_MAX_ROWS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  in_item_t               in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output out_item_t              out_data,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // sequencer
  rpff_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_pad   (in_data.pad),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath with row store
  rpff_dp #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  // a result is never loaded over one that is still held
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin |-> !(out_valid && out_stall))
    else $error("result loaded while output held");

  // the last pixel of a map returns the counters to the start
  a_map_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.fin && status.flushing && status.row_end) |=> (!status.emit && !status.flushing))
    else $error("counters not cleared after last pixel");

  // only a replaced pixel carries a fill amount
  a_fill_only_pit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.was_pit || (out_data.fill_amount == '0)))
    else $error("fill amount on a pixel that was not a pit");

  // no new item is taken while row store reads are in progress
  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_en |-> in_stall)
    else $error("input open during neighbor reads");
`endif

endmodule

// ===== bench/tb_top.sv =====
// tb_top: self-checking bench for raster_pit_fill_filter_unit, with a pixel scoreboard class
// depends on rpff_pkg and the rtl of the block; needs nothing else to run
`timescale 1ns / 100ps

module tb_top;
  import rpff_pkg::*;

  typedef enum int {HT_WIDE, HT_NEAR, HT_EDGE} height_mix_t;
  typedef enum int {RX_READY, RX_PATTERN, RX_HEAVY, RX_LIGHT} rx_mode_t;

  // predicts the filtered pixel stream and checks the block against it
  class pixel_scoreboard;
    logic signed [HEIGHT_BITS-1:0] line_buf [2][RPFF_MAX_COLS];
    logic [MAP_ROWS_W-1:0] rows_reg;
    logic [MAP_COLS_W-1:0] cols_reg;
    int unsigned row_idx;
    int unsigned col_idx;
    logic [FILL_SUM_W-1:0] fill_total;
    out_item_t pending_pixels [$];
    int mismatches;
    int pixels_checked;
    int pits_filled;
    int maps_done;

    function new();
      foreach (line_buf[i, j]) line_buf[i][j] = '0;
      rows_reg = MAP_ROWS_W'(1);
      cols_reg = MAP_COLS_W'(1);
      row_idx = 0;
      col_idx = 0;
      fill_total = '0;
      mismatches = 0;
      pixels_checked = 0;
      pits_filled = 0;
      maps_done = 0;
    endfunction

    function void take_config(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_MAP_ROWS) rows_reg = data[MAP_ROWS_W-1:0];
      else if (idx == REG_MAP_COLS) cols_reg = data[MAP_COLS_W-1:0];
    endfunction

    function void take_item(in_item_t item);
      int unsigned rows, cols, c, mp;
      bit flushing, row_end, pit;
      longint mid, nb, down, sum, mean, fill;
      int n;
      out_item_t px;
      // zero acts as one, oversize clamps to the store limits
      rows = (rows_reg == 0) ? 1 : ((rows_reg > RPFF_MAX_ROWS) ? RPFF_MAX_ROWS : rows_reg);
      cols = (cols_reg == 0) ? 1 : ((cols_reg > RPFF_MAX_COLS) ? RPFF_MAX_COLS : cols_reg);
      flushing = (row_idx >= rows);
      // a pad while pixels are due, or a pixel during the flush, is dropped
      if (flushing != item.pad) return;
      c = col_idx;
      row_end = (c + 1 >= cols);
      down = item.height_in;
      // the pixel one row up is complete now
      if (row_idx >= 1) begin
        mp = (row_idx - 1) & 1;
        mid = line_buf[mp][c];
        sum = 0;
        n = 0;
        pit = 1'b1;
        if (row_idx >= 2) begin
          nb = line_buf[row_idx & 1][c];
          sum += nb;
          n++;
          if (nb < mid) pit = 1'b0;
        end
        if (!flushing) begin
          sum += down;
          n++;
          if (down < mid) pit = 1'b0;
        end
        if (c > 0) begin
          nb = line_buf[mp][c-1];
          sum += nb;
          n++;
          if (nb < mid) pit = 1'b0;
        end
        if (c + 1 < cols) begin
          nb = line_buf[mp][c+1];
          sum += nb;
          n++;
          if (nb < mid) pit = 1'b0;
        end
        // lone pixel has no neighbors and passes through
        if (n == 0) pit = 1'b0;
        px = '0;
        px.height_out = mid[HEIGHT_BITS-1:0];
        if (pit) begin
          mean = sum / n;
          fill = mean - mid;
          fill_total = fill_total + fill[FILL_SUM_W-1:0];
          px.height_out = mean[HEIGHT_BITS-1:0];
          px.was_pit = 1'b1;
          px.fill_amount = fill[HEIGHT_BITS-1:0];
          pits_filled++;
        end
        px.last = flushing && row_end;
        px.total_fill = fill_total;
        pending_pixels.insert(pending_pixels.size(), px);
      end
      // flush walks the columns, then the map starts over
      if (flushing) begin
        if (row_end) begin
          row_idx = 0;
          col_idx = 0;
          fill_total = '0;
          maps_done++;
        end else begin
          col_idx = c + 1;
        end
        return;
      end
      line_buf[row_idx & 1][c] = down[HEIGHT_BITS-1:0];
      if (row_end) begin
        col_idx = 0;
        row_idx++;
      end else begin
        col_idx = c + 1;
      end
    endfunction

    function void check_pixel(out_item_t got);
      out_item_t want;
      if (pending_pixels.size() == 0) begin
        $error("unexpected pixel: height_out %0d was_pit %0d last %0d",
               got.height_out, got.was_pit, got.last);
        mismatches++;
        return;
      end
      want = pending_pixels.pop_front();
      pixels_checked++;
      if (got.height_out !== want.height_out) begin
        $error("height_out: expected %0d, actual %0d", want.height_out, got.height_out);
        mismatches++;
      end
      if (got.was_pit !== want.was_pit) begin
        $error("was_pit: expected %0d, actual %0d", want.was_pit, got.was_pit);
        mismatches++;
      end
      if (got.fill_amount !== want.fill_amount) begin
        $error("fill_amount: expected %0d, actual %0d", want.fill_amount, got.fill_amount);
        mismatches++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, actual %0d", want.last, got.last);
        mismatches++;
      end
      if (got.total_fill !== want.total_fill) begin
        $error("total_fill: expected %0d, actual %0d", want.total_fill, got.total_fill);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_item_t in_data;
  logic out_valid;
  logic out_stall;
  out_item_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  pixel_scoreboard board = new();
  rx_mode_t rx_mode = RX_READY;
  bit hold_request = 1'b0;
  bit gaps_on = 1'b0;
  int burst_left = 0;
  int map_h = 1;
  int map_w = 1;
  int items_sent = 0;
  int dropped_sent = 0;
  int random_items = 0;
  int setting_count = 0;

  raster_pit_fill_filter_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_pixel(out_data);
  end

  // receiver stall pattern, with an occasional long hold-off
  initial begin : receiver
    int hold_left;
    int tick;
    logic [15:0] pattern;
    hold_left = 0;
    tick = 0;
    pattern = '0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_left = 150;
        hold_request = 1'b0;
      end
      if (tick % 16 == 0) pattern = 16'($urandom);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        case (rx_mode)
          RX_PATTERN: out_stall <= pattern[tick % 16];
          RX_HEAVY:   out_stall <= ($urandom_range(0, 3) != 0);
          RX_LIGHT:   out_stall <= ($urandom_range(0, 7) == 0);
          default:    out_stall <= 1'b0;
        endcase
      end
      tick++;
    end
  end

  // run limit
  initial begin
    #10_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

  function automatic logic signed [HEIGHT_BITS-1:0] pick_height(height_mix_t mix, int base);
    int pick;
    pick = $urandom_range(0, 4);
    case (mix)
      HT_NEAR: return HEIGHT_BITS'(base + int'($urandom_range(0, 3)));
      HT_EDGE: begin
        case (pick)
          0: return 16'sh8000;
          1: return 16'sh7fff;
          2: return 16'sh0000;
          3: return -16'sd1;
          default: return HEIGHT_BITS'($urandom);
        endcase
      end
      default: return HEIGHT_BITS'($urandom);
    endcase
  endfunction

  // offer one item until taken, then maybe pause; called at a falling edge
  task automatic push_item(in_item_t item);
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.take_item(item);
    items_sent++;
    @(negedge clk);
    if (gaps_on) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
        burst_left = $urandom_range(0, 12);
      end
    end
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.take_config(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_map_size(logic [CFG_DATA_W-1:0] rows_data, logic [CFG_DATA_W-1:0] cols_data);
    int r, c;
    write_reg(REG_MAP_ROWS, rows_data);
    write_reg(REG_MAP_COLS, cols_data);
    r = int'(rows_data[MAP_ROWS_W-1:0]);
    c = int'(cols_data[MAP_COLS_W-1:0]);
    map_h = (r == 0) ? 1 : ((r > RPFF_MAX_ROWS) ? RPFF_MAX_ROWS : r);
    map_w = (c == 0) ? 1 : ((c > RPFF_MAX_COLS) ? RPFF_MAX_COLS : c);
    setting_count++;
  endtask

  // stop offering, let every result come out and the block settle
  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending_pixels.size() != 0) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  // one whole map plus its flush, with a few stray items the block must drop
  task automatic send_map(height_mix_t mix);
    int base;
    base = int'($urandom_range(0, 65532)) - 32768;
    for (int r = 0; r < map_h; r++) begin
      for (int c = 0; c < map_w; c++) begin
        if ($urandom_range(0, 15) == 0) begin
          push_item('{height_in: pick_height(HT_WIDE, 0), pad: 1'b1});
          dropped_sent++;
        end
        push_item('{height_in: pick_height(mix, base), pad: 1'b0});
        random_items++;
      end
    end
    for (int c = 0; c < map_w; c++) begin
      if ($urandom_range(0, 15) == 0) begin
        push_item('{height_in: pick_height(HT_WIDE, 0), pad: 1'b0});
        dropped_sent++;
      end
      push_item('{height_in: pick_height(HT_WIDE, 0), pad: 1'b1});
      random_items++;
    end
  endtask

  initial begin : stimulus
    int pit_grid [9];
    int top_grid [4];
    int phase;
    int rows_val;
    int cols_val;
    pit_grid = '{-2, -32768, -3, -1, -5, 32767, 32767, -7, -32768};
    top_grid = '{-32768, 32767, 32767, 32767};
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    rst_n = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset size is 1x1: stray pad, pixel, stray pixel in the flush, pad
    push_item('{height_in: -16'sd1, pad: 1'b1});
    push_item('{height_in: 16'sh8000, pad: 1'b0});
    push_item('{height_in: 16'sh7fff, pad: 1'b0});
    push_item('{height_in: 16'sh0000, pad: 1'b1});
    dropped_sent += 2;

    // 3x3 with a pit on a top edge whose mean truncates toward zero, corner pit
    drain();
    set_map_size(13'd3, 13'd3);
    foreach (pit_grid[i]) push_item('{height_in: HEIGHT_BITS'(pit_grid[i]), pad: 1'b0});
    repeat (3) push_item('{height_in: 16'sh0000, pad: 1'b1});

    // 2x2 with the largest fill and a flat pit of zero fill
    drain();
    set_map_size(13'd2, 13'd2);
    gaps_on = 1'b1;
    foreach (top_grid[i]) push_item('{height_in: HEIGHT_BITS'(top_grid[i]), pad: 1'b0});
    repeat (2) push_item('{height_in: 16'sh7fff, pad: 1'b1});

    // size extremes: tall single column, wide single row with high data bits set, zeros
    drain();
    set_map_size(13'd12, {2'b00, 11'd1});
    rx_mode = RX_LIGHT;
    hold_request = 1'b1;
    send_map(HT_NEAR);
    drain();
    set_map_size(13'd1, {2'b11, 11'd40});
    rx_mode = RX_PATTERN;
    send_map(HT_WIDE);
    drain();
    set_map_size(13'd0, {2'b10, 11'd0});
    send_map(HT_EDGE);
    send_map(HT_WIDE);

    // random sizes, contents and flow control
    random_items = 0;
    phase = 0;
    while (random_items < 480) begin
      drain();
      rows_val = $urandom_range(1, 6);
      cols_val = $urandom_range(1, 10);
      if (phase % 7 == 3) begin
        rows_val = $urandom_range(1, 2);
        cols_val = $urandom_range(11, 40);
      end
      if ($urandom_range(0, 9) == 0) rows_val = 0;
      if ($urandom_range(0, 9) == 0) cols_val = 0;
      set_map_size(rows_val[CFG_DATA_W-1:0], {2'($urandom), cols_val[MAP_COLS_W-1:0]});
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      gaps_on = ($urandom_range(0, 3) != 0);
      if (phase % 4 == 0) hold_request = 1'b1;
      repeat ($urandom_range(1, 3)) send_map(height_mix_t'($urandom_range(0, 2)));
      phase++;
    end

    drain();
    $display("tb_top: %0d items driven, %0d of them dropped by design; %0d pixels checked",
             items_sent, dropped_sent, board.pixels_checked);
    $display("tb_top: %0d pits filled over %0d maps and %0d size settings",
             board.pits_filled, board.maps_done, setting_count);
    if (board.mismatches == 0 && board.pending_pixels.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/rpff_pkg.sv
hdl/rpff_ram.sv
hdl/rpff_ctrl.sv
hdl/rpff_dp.sv
hdl/raster_pit_fill_filter_unit.sv
bench/tb_top.sv
